// ===== design/ecal_pkg.sv =====
// ----------------------------------------------------------------------------
// Epoch calendar package
// Shared widths, constants, result structs and helper functions for the
// epoch seconds to calendar date converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ecal_pkg;

  // Field widths.
  localparam int EPOCH_W = 32;
  localparam int YEAR_W  = 11;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;

  // Internal widths: day count, second of day, minute of day, day of year.
  localparam int DAYS_W  = 16;
  localparam int SOD_W   = 17;
  localparam int MOD_W   = 11;
  localparam int YDAY_W  = 9;

  // Register stages between the input and the output register: two in the
  // day split, then three in the date and time-of-day paths.
  localparam int PIPE_STAGES = 5;

  // First second of 2039-01-01; everything at or beyond it is out of range.
  localparam logic [EPOCH_W-1:0] LIMIT_SECS = 32'd2177452800;

  // Seconds to days: 86400 = 128 * 675, and the divide by 675 is a
  // reciprocal multiply that is exact for every 25-bit dividend.
  localparam logic [25:0] DAY_RECIP = 26'd50903317;
  localparam int          DAY_SHIFT = 35;
  localparam logic [9:0]  DAY_DIV   = 10'd675;

  // Days from 1968-01-01 (start of a leap cycle) to 1970-01-01.
  localparam logic [DAYS_W-1:0] DAY_OFS = 16'd731;

  // Four-year cycles: 1461 days, reciprocal exact for 16-bit dividends.
  localparam logic [15:0] QUAD_RECIP = 16'd45934;
  localparam int          QUAD_SHIFT = 26;
  localparam logic [15:0] QUAD_DAYS  = 16'd1461;

  // Day-in-cycle boundaries of the second, third and fourth year.
  localparam logic [10:0] YEAR1_START = 11'd366;
  localparam logic [10:0] YEAR2_START = 11'd731;
  localparam logic [10:0] YEAR3_START = 11'd1096;

  localparam logic [YEAR_W-1:0] BASE_YEAR = 11'd1968;

  // Divide by 15, exact for 15-bit dividends.
  localparam logic [15:0] DIV15_RECIP = 16'd34953;
  localparam int          DIV15_SHIFT = 19;

  localparam logic [6:0] MINUTE_LEN = 7'd60;

  // First day of year (0-based) of each month.
  localparam logic [YDAY_W-1:0] MONTH_START_COMMON [0:11] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };
  localparam logic [YDAY_W-1:0] MONTH_START_LEAP [0:11] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };

  // Calendar date of one beat.
  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
  } ecal_date_t;

  // Time of day of one beat.
  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
  } ecal_tod_t;

  // Floor of x / 15 by reciprocal multiply.
  function automatic logic [11:0] div15(input logic [14:0] x);
    logic [30:0] prod;
    logic [30:0] shifted;
    prod    = 31'(x) * 31'(DIV15_RECIP);
    shifted = prod >> DIV15_SHIFT;
    return shifted[11:0];
  endfunction

  // First day of year of month index idx (0 = January).
  function automatic logic [YDAY_W-1:0] month_start(input logic leap,
                                                    input logic [3:0] idx);
    logic [YDAY_W-1:0] val;
    val = '0;
    if (idx < 4'd12) begin
      val = leap ? MONTH_START_LEAP[idx] : MONTH_START_COMMON[idx];
    end
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== design/epoch_seconds_to_calendar.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar
// Converts seconds since 1970-01-01 00:00:00 UTC into Gregorian date and
// time of day, flagging results outside the years 1970 to 2038.
// ----------------------------------------------------------------------------
// Usage:
//   A beat enters when start is high and busy is low; in_epoch_seconds is
//   sampled at that clock edge. busy stays low, so a new beat may enter in
//   every cycle.
//   Each beat gives one result, shown for exactly one cycle with out_strobe
//   high. Results leave in entry order. Throughput is one beat per cycle.
//   Each beat passes through the pipeline: two stages split seconds into
//   days and second of day, three stages find the year and the time of
//   day, and the output register selects the date or the all-zero result.
//   Results from 2039-01-01 00:00:00 onward have out_valid_res low and all
//   fields zero.
//   Reset clears the valid bits of every stage, so beats in flight are
//   dropped and no strobe follows. The receiver cannot stall the block.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [ecal_pkg::EPOCH_W-1:0]  in_epoch_seconds,
  output logic                               out_strobe,
  output logic      [ecal_pkg::YEAR_W-1:0]   out_year,
  output logic      [ecal_pkg::MONTH_W-1:0]  out_month,
  output logic      [ecal_pkg::DAY_W-1:0]    out_day_of_month,
  output logic      [ecal_pkg::HOUR_W-1:0]   out_hour,
  output logic      [ecal_pkg::MIN_W-1:0]    out_minute,
  output logic      [ecal_pkg::SEC_W-1:0]    out_second,
  output logic                               out_valid_res
);
  import ecal_pkg::*;

  logic                   accept;
  logic                   in_range;
  logic [PIPE_STAGES-1:0] vld_r;
  logic [PIPE_STAGES-1:0] vld_nxt;
  logic [PIPE_STAGES-1:0] ok_r;
  logic [PIPE_STAGES-1:0] ok_nxt;
  logic [DAYS_W-1:0]      days;
  logic [SOD_W-1:0]       sod;
  ecal_date_t             date;
  ecal_tod_t              tod;
  ecal_date_t             date_nxt;
  ecal_tod_t              tod_nxt;
  ecal_date_t             date_r;
  ecal_tod_t              tod_r;
  logic                   strobe_r;
  logic                   ok_out_r;

  // The pipeline never stalls.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Range check on the raw input travels beside the data.
  assign in_range = (in_epoch_seconds < LIMIT_SECS);
  assign vld_nxt  = {vld_r[PIPE_STAGES-2:0], accept};
  assign ok_nxt   = {ok_r[PIPE_STAGES-2:0], in_range};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r <= ok_nxt;
  end

  // Seconds to day count and second of day.
  ecal_split u_split (
    .clk           (clk),
    .epoch_seconds (in_epoch_seconds),
    .days          (days),
    .sod           (sod)
  );

  // Day count to year, month and day.
  ecal_date u_date (
    .clk  (clk),
    .days (days),
    .date (date)
  );

  // Second of day to hour, minute and second.
  ecal_tod u_tod (
    .clk (clk),
    .sod (sod),
    .tod (tod)
  );

  // Output register: out-of-range results read as zero.
  assign date_nxt = ok_r[PIPE_STAGES-1] ? date : '0;
  assign tod_nxt  = ok_r[PIPE_STAGES-1] ? tod  : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= vld_r[PIPE_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    date_r   <= date_nxt;
    tod_r    <= tod_nxt;
    ok_out_r <= ok_r[PIPE_STAGES-1];
  end

  assign out_strobe       = strobe_r;
  assign out_year         = date_r.year;
  assign out_month        = date_r.month;
  assign out_day_of_month = date_r.day;
  assign out_hour         = tod_r.hour;
  assign out_minute       = tod_r.minute;
  assign out_second       = tod_r.second;
  assign out_valid_res    = ok_out_r;

  // Every accepted beat comes out as a strobed result.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##6 out_strobe)
    else $error("accepted beat did not produce a result after six cycles");

  // No result appears without a matching accepted beat.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, 6))
    else $error("result strobe without a matching accepted beat");

  // A valid result carries a date and time inside the calendar ranges.
  a_valid_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_valid_res) |->
      (out_year >= 11'd1970 && out_year <= 11'd2038 &&
       out_month >= 4'd1 && out_month <= 4'd12 &&
       out_day_of_month >= 5'd1 &&
       out_hour <= 5'd23 && out_minute <= 6'd59 && out_second <= 6'd59))
    else $error("valid result with a field out of range");

  // An out-of-range result is all zero.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_valid_res) |->
      (out_year == '0 && out_month == '0 && out_day_of_month == '0 &&
       out_hour == '0 && out_minute == '0 && out_second == '0))
    else $error("invalid result with nonzero fields");

endmodule

`default_nettype wire

// ===== design/ecal_split.sv =====
// ----------------------------------------------------------------------------
// Epoch calendar day split
// Two pipeline stages that break seconds since the epoch into a day count
// (offset to 1968-01-01) and the second of the day.
// ----------------------------------------------------------------------------
`default_nettype none

module ecal_split (
  input  wire logic                          clk,
  input  wire logic [ecal_pkg::EPOCH_W-1:0]  epoch_seconds,
  output logic      [ecal_pkg::DAYS_W-1:0]   days,
  output logic      [ecal_pkg::SOD_W-1:0]    sod
);
  import ecal_pkg::*;

  logic [24:0]       blk_a;
  logic [50:0]       prod_a;
  logic [50:0]       prod_sh_a;
  logic [15:0]       q_nxt;
  logic [15:0]       q_r;
  logic [24:0]       blk_r;
  logic [6:0]        low_r;
  logic [24:0]       back_b;
  logic [24:0]       rem_b;
  logic [DAYS_W-1:0] days_nxt;
  logic [SOD_W-1:0]  sod_nxt;
  logic [DAYS_W-1:0] days_r;
  logic [SOD_W-1:0]  sod_r;

  // Stage A: divide the 128-second block count by 675.
  assign blk_a     = epoch_seconds[31:7];
  assign prod_a    = 51'(blk_a) * 51'(DAY_RECIP);
  assign prod_sh_a = prod_a >> DAY_SHIFT;
  assign q_nxt     = prod_sh_a[15:0];

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    blk_r <= blk_a;
    low_r <= epoch_seconds[6:0];
  end

  // Stage B: remainder gives the second of the day; shift the day origin.
  assign back_b   = 25'(q_r) * 25'(DAY_DIV);
  assign rem_b    = blk_r - back_b;
  assign sod_nxt  = {rem_b[9:0], low_r};
  assign days_nxt = q_r + DAY_OFS;

  always_ff @(posedge clk) begin
    days_r <= days_nxt;
    sod_r  <= sod_nxt;
  end

  assign days = days_r;
  assign sod  = sod_r;

endmodule

`default_nettype wire

// ===== design/ecal_tod.sv =====
// ----------------------------------------------------------------------------
// Epoch calendar time of day
// Three pipeline stages that turn the second of the day into hour, minute
// and second.
// ----------------------------------------------------------------------------
`default_nettype none

module ecal_tod (
  input  wire logic                        clk,
  input  wire logic [ecal_pkg::SOD_W-1:0]  sod,
  output ecal_pkg::ecal_tod_t              tod
);
  import ecal_pkg::*;

  logic [11:0]      mod_q_c;
  logic [MOD_W-1:0] mod_nxt;
  logic [MOD_W-1:0] mod_r;
  logic [SOD_W-1:0] sod_r;
  logic [SOD_W-1:0] sec_full_d;
  logic [11:0]      hour_q_d;
  logic [SEC_W-1:0] sec_nxt;
  logic [HOUR_W-1:0] hour_nxt;
  logic [SEC_W-1:0] sec_r;
  logic [HOUR_W-1:0] hour_r;
  logic [MOD_W-1:0] mod_d_r;
  logic [MOD_W-1:0] min_full_e;
  logic [MIN_W-1:0] minute_nxt;
  logic [MIN_W-1:0] minute_e_r;
  logic [HOUR_W-1:0] hour_e_r;
  logic [SEC_W-1:0] sec_e_r;

  // Stage C: minute of the day = (second of day / 4) / 15.
  assign mod_q_c = div15(sod[16:2]);
  assign mod_nxt = mod_q_c[MOD_W-1:0];

  always_ff @(posedge clk) begin
    mod_r <= mod_nxt;
    sod_r <= sod;
  end

  // Stage D: second from the remainder, hour = (minute of day / 4) / 15.
  assign sec_full_d = sod_r - 17'(mod_r) * 17'(MINUTE_LEN);
  assign sec_nxt    = sec_full_d[SEC_W-1:0];
  assign hour_q_d   = div15(15'(mod_r[10:2]));
  assign hour_nxt   = hour_q_d[HOUR_W-1:0];

  always_ff @(posedge clk) begin
    sec_r   <= sec_nxt;
    hour_r  <= hour_nxt;
    mod_d_r <= mod_r;
  end

  // Stage E: minute from the remainder of the hour division.
  assign min_full_e = mod_d_r - 11'(hour_r) * 11'(MINUTE_LEN);
  assign minute_nxt = min_full_e[MIN_W-1:0];

  always_ff @(posedge clk) begin
    minute_e_r <= minute_nxt;
    hour_e_r   <= hour_r;
    sec_e_r    <= sec_r;
  end

  assign tod.hour   = hour_e_r;
  assign tod.minute = minute_e_r;
  assign tod.second = sec_e_r;

endmodule

`default_nettype wire

// ===== design/ecal_date.sv =====
// ----------------------------------------------------------------------------
// Epoch calendar date
// Three pipeline stages that turn a day count from 1968-01-01 into year and
// day of year, followed by the month table lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module ecal_date (
  input  wire logic                         clk,
  input  wire logic [ecal_pkg::DAYS_W-1:0]  days,
  output ecal_pkg::ecal_date_t              date
);
  import ecal_pkg::*;

  logic [31:0]        prod_c;
  logic [31:0]        prod_sh_c;
  logic [5:0]         cyc_nxt;
  logic [5:0]         cyc_r;
  logic [DAYS_W-1:0]  days_r;
  logic [DAYS_W-1:0]  dc_full_d;
  logic [10:0]        dc_nxt;
  logic [10:0]        dc_r;
  logic [5:0]         cyc_d_r;
  logic [1:0]         yoff;
  logic [10:0]        yday_full;
  logic               leap_nxt;
  logic [YEAR_W-1:0]  year_nxt;
  logic [YDAY_W-1:0]  yday_nxt;
  logic [YEAR_W-1:0]  year_r;
  logic [YDAY_W-1:0]  yday_r;
  logic               leap_r;
  logic [3:0]         cnt;
  logic [YDAY_W-1:0]  day_full;

  // Stage C: four-year cycle index by reciprocal multiply.
  assign prod_c    = 32'(days) * 32'(QUAD_RECIP);
  assign prod_sh_c = prod_c >> QUAD_SHIFT;
  assign cyc_nxt   = prod_sh_c[5:0];

  always_ff @(posedge clk) begin
    cyc_r  <= cyc_nxt;
    days_r <= days;
  end

  // Stage D: day within the cycle.
  assign dc_full_d = days_r - 16'(cyc_r) * QUAD_DAYS;
  assign dc_nxt    = dc_full_d[10:0];

  always_ff @(posedge clk) begin
    dc_r    <= dc_nxt;
    cyc_d_r <= cyc_r;
  end

  // Stage E: year within the cycle; the first year of a cycle is leap.
  always_comb begin
    priority if (dc_r < YEAR1_START) begin
      yoff      = 2'd0;
      yday_full = dc_r;
    end else if (dc_r < YEAR2_START) begin
      yoff      = 2'd1;
      yday_full = dc_r - YEAR1_START;
    end else if (dc_r < YEAR3_START) begin
      yoff      = 2'd2;
      yday_full = dc_r - YEAR2_START;
    end else begin
      yoff      = 2'd3;
      yday_full = dc_r - YEAR3_START;
    end
  end

  assign leap_nxt = (yoff == 2'd0);
  assign yday_nxt = yday_full[YDAY_W-1:0];
  assign year_nxt = BASE_YEAR + 11'({cyc_d_r, 2'b00}) + 11'(yoff);

  always_ff @(posedge clk) begin
    year_r <= year_nxt;
    yday_r <= yday_nxt;
    leap_r <= leap_nxt;
  end

  // Month lookup: count the month starts already passed.
  always_comb begin
    cnt = '0;
    for (int i = 1; i < 12; i++) begin
      if (yday_r >= month_start(leap_r, 4'(i))) begin
        cnt = cnt + 4'd1;
      end
    end
  end

  assign day_full   = yday_r - month_start(leap_r, cnt) + 9'd1;
  assign date.year  = year_r;
  assign date.month = cnt + 4'd1;
  assign date.day   = day_full[DAY_W-1:0];

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Epoch seconds to calendar testbench
// Feeds timestamps into the converter and checks every result against a
// calendar computation done in the bench. A short list of corner cases
// comes first: the epoch, leap days, year ends, the last valid second and
// the top of the 32-bit range. Random timestamps follow, a quarter of them
// on average near a midnight, under several input pacing phases.
// ----------------------------------------------------------------------------

module tb_top;
  import ecal_pkg::*;

  localparam int     CYCLE_LIMIT  = 200000;
  localparam int     DRAIN_CYCLES = 20;
  localparam longint SECS_IN_DAY  = 86400;
  localparam longint SECS_IN_YEAR = 31536000;
  localparam longint FIRST_YEAR   = 1970;
  localparam longint LAST_YEAR    = 2038;
  localparam longint TOP_SECS     = 64'hFFFF_FFFF;

  // Last day of year (0-based) of each month; entry 0 stands before January.
  localparam int LAST_YDAY_LEAP [0:12] = '{
    -1, 30, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365
  };
  localparam int LAST_YDAY_COMMON [0:12] = '{
    -1, 30, 58, 89, 119, 150, 180, 211, 242, 272, 303, 333, 364
  };

  // Corner-case timestamps sent before the random part.
  localparam logic [EPOCH_W-1:0] CORNER_SECS [0:24] = '{
    32'd0,            // 1970-01-01 00:00:00
    32'd43199,        // just before noon on the first day
    32'd86399,        // last second of the first day
    32'd86400,        // second day
    32'd68169599,     // 1972-02-28 23:59:59
    32'd68169600,     // 1972-02-29, first leap day
    32'd94694399,     // 1972-12-31 23:59:59
    32'd94694400,     // 1973-01-01
    32'd946684799,    // 1999-12-31 23:59:59
    32'd946684800,    // 2000-01-01
    32'd951782400,    // 2000-02-29, century leap day
    32'd951868800,    // 2000-03-01
    32'd978307199,    // 2000-12-31 23:59:59
    32'd2114380799,   // 2036-12-31 23:59:59
    32'd2145916800,   // 2038-01-01
    32'h7FFF_FFFF,    // 2038-01-19 03:14:07
    32'h8000_0000,
    32'd2177452799,   // last valid second, 2038-12-31 23:59:59
    32'd2177452800,   // first out-of-range second, 2039-01-01
    32'd2177539199,
    32'd4107542400,   // 2100-03-01, century without a leap day
    32'h5555_5555,
    32'hAAAA_AAAA,
    32'hFFFF_FFFE,
    32'hFFFF_FFFF     // top of the range, year 2106
  };

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day_of_month;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic               valid;
  } civil_time_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [EPOCH_W-1:0] in_epoch_seconds;
  logic               out_strobe;
  logic [YEAR_W-1:0]  out_year;
  logic [MONTH_W-1:0] out_month;
  logic [DAY_W-1:0]   out_day_of_month;
  logic [HOUR_W-1:0]  out_hour;
  logic [MIN_W-1:0]   out_minute;
  logic [SEC_W-1:0]   out_second;
  logic               out_valid_res;

  logic [EPOCH_W-1:0] epoch_queue[$];
  civil_time_t        expected_dates[$];
  int                 gap_pct;
  int                 cycle_count;
  int                 error_count;
  int                 beats_taken;
  int                 results_seen;
  int                 out_of_range;

  epoch_seconds_to_calendar u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_epoch_seconds (in_epoch_seconds),
    .out_strobe       (out_strobe),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .out_valid_res    (out_valid_res)
  );

  // Clock with a period of 10.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Gregorian rule: every fourth year, except centuries not divisible by 400.
  function automatic bit is_leap_year(input longint yr);
    return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
  endfunction

  // Number of leap years in 1..n.
  function automatic longint leap_count(input longint n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  function automatic int last_yday(input bit leap, input int idx);
    return leap ? LAST_YDAY_LEAP[idx] : LAST_YDAY_COMMON[idx];
  endfunction

  // Calendar date and time of day of one timestamp, zero past 2038.
  function automatic civil_time_t civil_from_epoch(input logic [EPOCH_W-1:0] secs);
    civil_time_t f;
    longint      yr;
    longint      rest;
    longint      yday;
    longint      sod;
    int          mon;
    bit          leap;
    f = '0;
    f.epoch = secs;
    yr = FIRST_YEAR + longint'(secs) / SECS_IN_YEAR;
    rest = longint'(secs) - (yr - FIRST_YEAR) * SECS_IN_YEAR;
    rest -= (leap_count(yr - 1) - leap_count(FIRST_YEAR - 1)) * SECS_IN_DAY;
    // The leap-day correction may push the estimate back by one year.
    if (rest < 0) begin
      yr -= 1;
      rest += SECS_IN_YEAR;
      if (is_leap_year(yr)) begin
        rest += SECS_IN_DAY;
      end
    end
    leap = is_leap_year(yr);
    yday = rest / SECS_IN_DAY;
    sod = rest - yday * SECS_IN_DAY;
    mon = 1;
    while (mon < 12 && last_yday(leap, mon) < yday) begin
      mon++;
    end
    if (yr >= FIRST_YEAR && yr <= LAST_YEAR) begin
      f.year         = YEAR_W'(yr);
      f.month        = MONTH_W'(mon);
      f.day_of_month = DAY_W'(yday - last_yday(leap, mon - 1));
      f.hour         = HOUR_W'(sod / 3600);
      f.minute       = MIN_W'((sod % 3600) / 60);
      f.second       = SEC_W'(sod % 60);
      f.valid        = 1'b1;
    end
    return f;
  endfunction

  // First second of January 1 of a year from 1970 on.
  function automatic longint year_start_secs(input longint yr);
    longint days;
    days = 0;
    for (longint y = FIRST_YEAR; y < yr; y++) begin
      days += is_leap_year(y) ? 366 : 365;
    end
    return days * SECS_IN_DAY;
  endfunction

  // Random timestamp: uniform over the whole range or the valid years, or any
  // day to 2106, half near midnight, so many land on day, month and year ends.
  function automatic logic [EPOCH_W-1:0] pick_timestamp();
    longint t;
    t = 0;
    case ($urandom_range(9))
      0, 1: begin
        t = $urandom;
      end
      2, 3, 4: begin
        t = $urandom_range(LIMIT_SECS - 1, 0);
      end
      default: begin
        t = year_start_secs($urandom_range(2106, 1970)) +
            longint'($urandom_range(365)) * SECS_IN_DAY;
        if ($urandom_range(1)) begin
          t += longint'($urandom_range(4)) - 2;
        end else begin
          t += $urandom_range(86399);
        end
      end
    endcase
    if (t < 0) begin
      t = 0;
    end else if (t > TOP_SECS) begin
      t = TOP_SECS;
    end
    return EPOCH_W'(t);
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got, input logic [EPOCH_W-1:0] secs);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch for epoch %0d: expected %0d, actual %0d",
               $time, name, secs, want, got);
    end
  endtask

  // Queue a batch of random timestamps at one pacing and wait for all results.
  task automatic run_phase(input int count, input int pct);
    gap_pct = pct;
    repeat (count) begin
      epoch_queue.push_back(pick_timestamp());
    end
    while (epoch_queue.size() != 0 || expected_dates.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Driver: present the oldest pending timestamp unless idling this cycle.
  always @(negedge clk) begin
    if (!rst_n) begin
      start            <= 1'b0;
      in_epoch_seconds <= '0;
    end else if (epoch_queue.size() != 0 && $urandom_range(99) >= gap_pct) begin
      start            <= 1'b1;
      in_epoch_seconds <= epoch_queue[0];
    end else begin
      start            <= 1'b0;
      in_epoch_seconds <= $urandom;
    end
  end

  // Monitor: predict on every accepted beat and check every strobed result.
  always @(posedge clk) begin : monitor
    civil_time_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, expected_dates.size());
      $display("tb_top failed");
      $finish;
    end else if (rst_n) begin
      if (start && !busy) begin
        expected_dates.push_back(civil_from_epoch(in_epoch_seconds));
        void'(epoch_queue.pop_front());
        beats_taken++;
      end
      if (out_strobe) begin
        results_seen++;
        if (!out_valid_res) begin
          out_of_range++;
        end
        if (expected_dates.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, year %0d month %0d day %0d valid %0b",
                   $time, out_year, out_month, out_day_of_month, out_valid_res);
        end else begin
          want = expected_dates.pop_front();
          check_field("year", want.year, out_year, want.epoch);
          check_field("month", want.month, out_month, want.epoch);
          check_field("day_of_month", want.day_of_month, out_day_of_month, want.epoch);
          check_field("hour", want.hour, out_hour, want.epoch);
          check_field("minute", want.minute, out_minute, want.epoch);
          check_field("second", want.second, out_second, want.epoch);
          check_field("valid_res", want.valid, out_valid_res, want.epoch);
        end
      end
    end
  end

  // Stimulus sequence and end of run.
  initial begin
    rst_n            = 1'b0;
    start            = 1'b0;
    in_epoch_seconds = '0;
    gap_pct          = 0;
    cycle_count      = 0;
    error_count      = 0;
    beats_taken      = 0;
    results_seen     = 0;
    out_of_range     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Corner cases back to back, then random phases of different pacing.
    foreach (CORNER_SECS[i]) begin
      epoch_queue.push_back(CORNER_SECS[i]);
    end
    run_phase(700, 0);
    run_phase(350, 87);
    run_phase(500, 28);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d timestamps under no, heavy and light input gaps;", beats_taken);
    $display("%0d results checked, %0d of them past 2038.", results_seen, out_of_range);
    if (error_count == 0 && expected_dates.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ecal_pkg.sv
design/ecal_split.sv
design/ecal_tod.sv
design/ecal_date.sv
design/epoch_seconds_to_calendar.sv
sim/tb_top.sv
